/* rtl/core/vector_arith_distance_core_defines.svh */
// assertion macros shared by the vector arithmetic and distance core
`ifndef VECTOR_ARITH_DISTANCE_CORE_DEFINES_SVH
`define VECTOR_ARITH_DISTANCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication under synchronous reset
`define VAD_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("vad assertion failed");

// next-cycle implication under synchronous reset
`define VAD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("vad assertion failed");

`else

`define VAD_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define VAD_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* rtl/core/vad_pkg.sv */
// shared types and constants of the vector arithmetic and distance core
`timescale 1ns / 1ps

package vad_pkg;

    localparam int ACC_WIDTH  = 48;
    localparam int OUT_WIDTH  = 48;
    localparam int MODE_WIDTH = 2;

    // saturation limits of the accumulator
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ADD  = 2'd0,
        MODE_SUB  = 2'd1,
        MODE_DOT  = 2'd2,
        MODE_DIST = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_ROOT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // finished result offered by the engine to the output stage
    typedef struct packed {
        logic                 valid;
        logic [OUT_WIDTH-1:0] value;
    } t_res;

endpackage

/* rtl/core/vad_in_if.sv */
// request channel carrying one element pair with its mode and last mark
`timescale 1ns / 1ps

interface vad_in_if
    import vad_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) ();

    logic                  valid;
    logic                  ready;
    logic [MODE_WIDTH-1:0] mode;
    logic [ELEM_WIDTH-1:0] elem_a;
    logic [ELEM_WIDTH-1:0] elem_b;
    logic                  last;

    modport source (output valid, output mode, output elem_a, output elem_b,
                    output last, input ready);
    modport sink   (input valid, input mode, input elem_a, input elem_b,
                    input last, output ready);

endinterface

/* rtl/core/vad_out_if.sv */
// result channel carrying one value
`timescale 1ns / 1ps

interface vad_out_if
    import vad_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [OUT_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

/* rtl/core/vad_alu.sv */
// shared adder-subtractor used by multiply, accumulate and root steps
`timescale 1ns / 1ps

module vad_alu #(
    parameter int WIDTH = 50
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_neg
);

    // a + b, or a - b as a + ~b + 1
    assign o_sum = i_a + (i_b ^ {WIDTH{i_sub}}) + WIDTH'(i_sub);
    assign o_neg = o_sum[WIDTH-1];

endmodule

/* rtl/core/vad_engine.sv */
// sequencer and datapath: shift-add multiply, saturating accumulate, integer root
`timescale 1ns / 1ps
`include "vector_arith_distance_core_defines.svh"

module vad_engine
    import vad_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vad_in_if.sink        i_req,
    input  logic          i_out_free,
    output t_res          o_res
);

    localparam int W  = ELEM_WIDTH;
    localparam int PW = 2 * W;
    localparam int AW = (PW + 2 > ACC_WIDTH + 2) ? PW + 2 : ACC_WIDTH + 2;
    localparam int CW = $clog2(W + 1);
    localparam int BW = ACC_WIDTH - 1;

    localparam logic [AW-1:0] MAG_CAP    = AW'(1) << ACC_WIDTH;
    localparam logic [BW-1:0] ROOT_FIRST = BW'(1) << (ACC_WIDTH - 2);

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic                 r_last, n_last;
    logic                 r_neg, n_neg;
    logic [PW-1:0]        r_mcand, n_mcand;
    logic [W-1:0]         r_mplier, n_mplier;
    logic [PW-1:0]        r_prod, n_prod;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [ACC_WIDTH-1:0] r_acc, n_acc;
    logic [ACC_WIDTH-1:0] r_x, n_x;
    logic [ACC_WIDTH-1:0] r_root, n_root;
    logic [BW-1:0]        r_bit, n_bit;
    logic [OUT_WIDTH-1:0] r_value, n_value;

    logic                 accept;
    logic [W-1:0]         elem_a, elem_b;
    logic [W:0]           sum_ab, diff_ab, diff_neg;
    logic [W-1:0]         mag_a, mag_b, mag_d;

    logic [AW-1:0]        alu_a, alu_b, alu_sum;
    logic                 alu_sub, alu_neg;

    logic [AW-1:0]        prod_ext, term_mag;
    logic                 term_big;
    logic                 acc_in_range;
    logic [ACC_WIDTH-1:0] acc_new;
    logic [ACC_WIDTH-1:0] root_try;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign elem_a      = i_req.elem_a;
    assign elem_b      = i_req.elem_b;

    // element sum, difference and magnitudes at request time
    assign sum_ab   = {elem_a[W-1], elem_a} + {elem_b[W-1], elem_b};
    assign diff_ab  = {elem_a[W-1], elem_a} - {elem_b[W-1], elem_b};
    assign diff_neg = (~diff_ab) + (W+1)'(1);
    assign mag_a    = elem_a[W-1] ? ((~elem_a) + W'(1)) : elem_a;
    assign mag_b    = elem_b[W-1] ? ((~elem_b) + W'(1)) : elem_b;
    assign mag_d    = diff_ab[W] ? diff_neg[W-1:0] : diff_ab[W-1:0];

    // product magnitude capped at 2^48 before it enters the accumulator
    assign prod_ext = AW'(r_prod);
    assign term_big = (|prod_ext[AW-1:ACC_WIDTH+1])
                      || (prod_ext[ACC_WIDTH] && (|prod_ext[ACC_WIDTH-1:0]));
    assign term_mag = term_big ? MAG_CAP : prod_ext;

    // root trial value, bits of root and trial bit never overlap
    assign root_try = r_root | {1'b0, r_bit};

    // operand selection for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                alu_a = prod_ext;
                alu_b = r_mplier[0] ? AW'(r_mcand) : '0;
            end
            S_ACC: begin
                alu_a   = {{(AW-ACC_WIDTH){r_acc[ACC_WIDTH-1]}}, r_acc};
                alu_b   = term_mag;
                alu_sub = r_neg;
            end
            S_ROOT: begin
                alu_a   = AW'(r_x);
                alu_b   = AW'(root_try);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    vad_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_neg (alu_neg)
    );

    // saturate the accumulated sum to 48 bits
    assign acc_in_range = (&alu_sum[AW-1:ACC_WIDTH-1]) || !(|alu_sum[AW-1:ACC_WIDTH-1]);
    assign acc_new      = acc_in_range ? alu_sum[ACC_WIDTH-1:0]
                                       : (alu_neg ? ACC_MIN : ACC_MAX);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_last   = r_last;
        n_neg    = r_neg;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_prod   = r_prod;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_x      = r_x;
        n_root   = r_root;
        n_bit    = r_bit;
        n_value  = r_value;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = t_mode'(i_req.mode);
                    n_last = i_req.last;
                    n_prod = '0;
                    n_cnt  = CW'(W);
                    case (t_mode'(i_req.mode))
                        MODE_ADD: begin
                            n_value = {{(OUT_WIDTH-W-1){sum_ab[W]}}, sum_ab};
                            n_state = S_DONE;
                            if (i_req.last) begin
                                n_acc = '0;
                            end
                        end
                        MODE_SUB: begin
                            n_value = {{(OUT_WIDTH-W-1){diff_ab[W]}}, diff_ab};
                            n_state = S_DONE;
                            if (i_req.last) begin
                                n_acc = '0;
                            end
                        end
                        MODE_DOT: begin
                            n_mcand  = PW'(mag_a);
                            n_mplier = mag_b;
                            n_neg    = elem_a[W-1] ^ elem_b[W-1];
                            n_state  = S_MUL;
                        end
                        default: begin
                            n_mcand  = PW'(mag_d);
                            n_mplier = mag_d;
                            n_neg    = 1'b0;
                            n_state  = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_prod   = alu_sum[PW-1:0];
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!r_last) begin
                    n_acc   = acc_new;
                    n_state = S_IDLE;
                end else begin
                    n_acc = '0;
                    if (r_mode == MODE_DOT) begin
                        n_value = acc_new;
                        n_state = S_DONE;
                    end else if (acc_new[ACC_WIDTH-1]) begin
                        n_value = '0;
                        n_state = S_DONE;
                    end else begin
                        n_x     = acc_new;
                        n_root  = '0;
                        n_bit   = ROOT_FIRST;
                        n_state = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (!alu_neg) begin
                    n_x    = alu_sum[ACC_WIDTH-1:0];
                    n_root = (r_root >> 1) | {1'b0, r_bit};
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_value = OUT_WIDTH'(n_root);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
    end

    // working registers of the current request
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_last   <= n_last;
        r_neg    <= n_neg;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
        r_cnt    <= n_cnt;
        r_x      <= n_x;
        r_root   <= n_root;
        r_bit    <= n_bit;
        r_value  <= n_value;
    end

    // result offer
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.value = r_value;

    // checks
    `VAD_ASSERT_NEXT(a_mul_ends_in_acc, i_clk, i_rst_n, (r_state == S_MUL) && (r_cnt == CW'(1)), r_state == S_ACC)
    `VAD_ASSERT_NEXT(a_last_clears_acc, i_clk, i_rst_n, (r_state == S_ACC) && r_last, r_acc == '0)
    `VAD_ASSERT_IMPL(a_root_only_dist_last, i_clk, i_rst_n, r_state == S_ROOT, (r_mode == MODE_DIST) && r_last)
    `VAD_ASSERT_NEXT(a_done_hands_off, i_clk, i_rst_n, (r_state == S_DONE) && i_out_free, r_state == S_IDLE)

endmodule

/* rtl/core/vector_arith_distance_core.sv */
// top level of the vector arithmetic and distance core with its output register
`timescale 1ns / 1ps

// Streams element pairs of two signed Q8.8 vectors, one pair per request. Add and subtract
// requests return a+b or a-b at once. Dot requests accumulate a*b (Q16.16) and distance
// requests accumulate (a-b)^2 into one 48-bit accumulator that saturates at its range; on
// the request marked last the core returns the dot sum or floor(sqrt(sum)) (Q8.8; zero for
// a negative sum) and clears the accumulator. Norm is distance with elem_b held at zero.
// A dot or distance element runs the shift-add multiplier, which retires one multiplier
// bit per cycle through the shared adder, and then an accumulate step; a last distance
// element then runs the bit-pair steps of the square root on the same adder. A finished
// result sits in an output register, so the core takes the next request while that result
// waits.
module vector_arith_distance_core
    import vad_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vad_in_if.sink     i_req,
    vad_out_if.source  o_res
);

    t_res                 eng_res;
    logic                 out_free;
    logic                 r_out_valid;
    logic [OUT_WIDTH-1:0] r_out_value;

    vad_engine #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_out_free (out_free),
        .o_res      (eng_res)
    );

    // output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || o_res.ready;

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (eng_res.valid && out_free) begin
            r_out_value <= eng_res.value;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.value = r_out_value;

endmodule

/* tb/sv/vad_value_checker.sv */
// request and result monitor with value prediction for the vector arithmetic and distance core
`timescale 1ns / 1ps

module vad_value_checker
    import vad_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [MODE_WIDTH-1:0] i_mode,
    input  logic [ELEM_WIDTH-1:0] i_elem_a,
    input  logic [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                  i_last,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_WIDTH-1:0]  i_res_value,
    output int                    o_fail_count,
    output int                    o_owed
);

    // saturation bounds of the running sum, widened to 64 bits
    localparam longint SUM_HI = longint'($signed(ACC_MAX));
    localparam longint SUM_LO = longint'($signed(ACC_MIN));

    // model copy of the shared dot / distance accumulator
    longint running_sum;

    // values the core still owes, oldest first
    logic [OUT_WIDTH-1:0] owed_values[$];

    initial begin
        o_fail_count = 0;
        o_owed       = 0;
        running_sum  = 0;
    end

    // add one term and clamp at the accumulator range
    function automatic longint clamp_add(input longint sum, input longint term);
        longint total;
        total = sum + term;
        if (total > SUM_HI) total = SUM_HI;
        if (total < SUM_LO) total = SUM_LO;
        return total;
    endfunction

    // floor of the square root, one result bit at a time
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    // advance the running sum by one element pair; returns 1 when a value comes out
    function automatic bit step_pair(input t_mode m,
                                     input logic signed [ELEM_WIDTH-1:0] a,
                                     input logic signed [ELEM_WIDTH-1:0] b,
                                     input logic lst,
                                     output logic [OUT_WIDTH-1:0] value);
        longint ea;
        longint eb;
        longint outv;
        bit     emit;
        ea   = a;
        eb   = b;
        outv = 0;
        emit = 1'b0;
        case (m)
            MODE_ADD: begin
                outv = ea + eb;
                emit = 1'b1;
            end
            MODE_SUB: begin
                outv = ea - eb;
                emit = 1'b1;
            end
            MODE_DOT: begin
                // terms stay far below the 2^48 magnitude clip
                running_sum = clamp_add(running_sum, ea * eb);
                outv        = running_sum;
                emit        = lst;
            end
            default: begin
                running_sum = clamp_add(running_sum, (ea - eb) * (ea - eb));
                // a negative sum only comes from mixing dot items in
                outv        = (running_sum < 0) ? 0 : longint'(floor_root(running_sum));
                emit        = lst;
            end
        endcase
        if (lst) running_sum = 0;
        value = outv[OUT_WIDTH-1:0];
        return emit;
    endfunction

    // compare results first, then record what each new request owes
    always @(posedge i_clk) begin
        logic [OUT_WIDTH-1:0] want;
        logic [OUT_WIDTH-1:0] fresh;
        if (!i_rst_n) begin
            running_sum = 0;
            owed_values.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (owed_values.size() == 0) begin
                    $error("value: no result expected, actual %0d", $signed(i_res_value));
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = owed_values.pop_front();
                    if (want !== i_res_value) begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want), $signed(i_res_value));
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (step_pair(t_mode'(i_mode), $signed(i_elem_a), $signed(i_elem_b),
                              i_last, fresh))
                    owed_values.push_back(fresh);
            end
        end
        o_owed = owed_values.size();
    end

endmodule

/* tb/sv/tb.sv */
// stimulus, flow control and verdict for the vector arithmetic and distance core
`timescale 1ns / 1ps

module tb;
    import vad_pkg::*;

    localparam int ELEM_W           = 16;
    localparam int RANDOM_PAIRS     = 680;
    localparam int QUIET_TAIL       = 100;
    localparam int LONG_VEC_PAIRS   = 16;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic i_clk;
    logic i_rst_n;

    int  fail_count;
    int  owed_count;
    int  pairs_sent;
    int  idle_cycles;
    bit  drain_quiet;
    bit  long_hold_armed;

    vad_in_if #(.ELEM_WIDTH(ELEM_W)) req_if ();
    vad_out_if                       res_if ();

    vector_arith_distance_core #(
        .ELEM_WIDTH(ELEM_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    vad_value_checker #(
        .ELEM_WIDTH(ELEM_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_mode      (req_if.mode),
        .i_elem_a    (req_if.elem_a),
        .i_elem_b    (req_if.elem_b),
        .i_last      (req_if.last),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res_value (res_if.value),
        .o_fail_count(fail_count),
        .o_owed      (owed_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog on cycles with no handshake on either channel
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side back-pressure: short random bursts, one long hold when armed
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else if (!drain_quiet && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // random element with extra weight on the extremes and small values
    function automatic logic [ELEM_W-1:0] random_elem();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    // offer one element pair and hold it until the core takes it
    task automatic send_pair(input t_mode m, input logic [ELEM_W-1:0] a,
                             input logic [ELEM_W-1:0] b, input logic lst,
                             input bit allow_gap);
        if (allow_gap && !drain_quiet && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.mode   <= m;
        req_if.elem_a <= a;
        req_if.elem_b <= b;
        req_if.last   <= lst;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        pairs_sent++;
    endtask

    // main stimulus and verdict
    initial begin
        int    len;
        int    kind;
        t_mode m;
        bit    norm;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.mode     = MODE_ADD;
        req_if.elem_a   = '0;
        req_if.elem_b   = '0;
        req_if.last     = 1'b0;
        pairs_sent      = 0;
        drain_quiet     = 1'b0;
        long_hold_armed = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes for add and subtract, last on an add clears nothing visible
        send_pair(MODE_ADD, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1);
        send_pair(MODE_ADD, 16'h8000, 16'h8000, 1'b0, 1'b1);
        send_pair(MODE_ADD, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
        send_pair(MODE_SUB, 16'h7FFF, 16'h8000, 1'b0, 1'b1);
        send_pair(MODE_SUB, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
        send_pair(MODE_SUB, 16'h0000, 16'h0000, 1'b1, 1'b1);
        // dot product with extreme and zero terms of either sign
        send_pair(MODE_DOT, 16'h7FFF, 16'h8000, 1'b0, 1'b1);
        send_pair(MODE_DOT, 16'h8000, 16'h8000, 1'b0, 1'b1);
        send_pair(MODE_DOT, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
        send_pair(MODE_DOT, 16'h0001, 16'h0000, 1'b1, 1'b1);
        // widest single distance, then a norm of (3, 4)
        send_pair(MODE_DIST, 16'h7FFF, 16'h8000, 1'b1, 1'b1);
        send_pair(MODE_DIST, 16'h0300, 16'h0000, 1'b0, 1'b1);
        send_pair(MODE_DIST, 16'h0400, 16'h0000, 1'b1, 1'b1);
        // negative sum reaching a distance end gives zero
        send_pair(MODE_DOT, 16'hFF00, 16'h0100, 1'b0, 1'b1);
        send_pair(MODE_DIST, 16'h0000, 16'h0000, 1'b1, 1'b1);
        // root of 10 truncates to 3
        send_pair(MODE_DIST, 16'h0003, 16'h0000, 1'b0, 1'b1);
        send_pair(MODE_DIST, 16'h0000, 16'h0001, 1'b1, 1'b1);
        // last on an add item clears the pending dot sum
        send_pair(MODE_DOT, 16'h0100, 16'h0100, 1'b0, 1'b1);
        send_pair(MODE_ADD, 16'h0001, 16'h0002, 1'b1, 1'b1);
        send_pair(MODE_DOT, 16'h0001, 16'h0001, 1'b1, 1'b1);
        // distance items ended by a dot item emit the raw sum
        send_pair(MODE_DIST, 16'h0001, 16'h0000, 1'b0, 1'b1);
        send_pair(MODE_DOT, 16'h0000, 16'h0000, 1'b1, 1'b1);

        // long vector of widest distance terms, read back raw
        for (int i = 0; i < LONG_VEC_PAIRS; i++)
            send_pair(MODE_DIST, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
        send_pair(MODE_DOT, 16'h0000, 16'h0000, 1'b1, 1'b0);

        // long result hold while add requests keep coming back to back
        long_hold_armed = 1'b1;
        for (int i = 0; i < 24; i++)
            send_pair(MODE_ADD, random_elem(), random_elem(), 1'($urandom_range(0, 1)), 1'b0);

        // random traffic, mostly whole vectors
        pairs_sent = 0;
        while (pairs_sent < RANDOM_PAIRS) begin
            drain_quiet = (pairs_sent >= RANDOM_PAIRS - QUIET_TAIL);
            kind        = $urandom_range(0, 19);
            if (kind < 5) begin
                m = $urandom_range(0, 1) ? MODE_SUB : MODE_ADD;
                send_pair(m, random_elem(), random_elem(), 1'($urandom_range(0, 1)), 1'b1);
            end else if (kind < 18) begin
                m    = $urandom_range(0, 1) ? MODE_DIST : MODE_DOT;
                norm = (m == MODE_DIST) && ($urandom_range(0, 3) == 0);
                len  = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_pair(m, random_elem(), norm ? '0 : random_elem(),
                              (i == len - 1), 1'b1);
            end else begin
                // mixed modes and stray last marks
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_pair(t_mode'($urandom_range(0, 3)), random_elem(), random_elem(),
                              1'($urandom_range(0, 1)), 1'b1);
            end
        end
        // close any open vector so its sum is checked too
        send_pair(MODE_DIST, random_elem(), random_elem(), 1'b1, 1'b0);
        req_if.valid <= 1'b0;

        // let all owed values come back, then a quiet tail
        while (owed_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && owed_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
